// File: rtl/alarm_priority_rotator_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the alarm priority rotator checker
// Clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ALARM_PRIORITY_ROTATOR_TOP_ASSERT_SVH
`define ALARM_PRIORITY_ROTATOR_TOP_ASSERT_SVH

// Same-cycle implication.
`define APR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("alarm priority rotator check failed");

// Next-cycle implication.
`define APR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("alarm priority rotator check failed");

`endif

// File: rtl/apr_pkg.sv
// ----------------------------------------------------------------------------
// apr_pkg
// Widths, state codes and stream layout shared by the alarm priority rotator.
// ----------------------------------------------------------------------------
package apr_pkg;

    localparam int STATE_W = 2;
    localparam int LEVEL_W = 3;
    localparam int KIND_W  = 3;
    localparam int MSG_W   = 6;

    // Packed widths of the stream data words, rounded up to whole bytes.
    localparam int IN_FIELDS_W  = STATE_W + 3 + LEVEL_W + KIND_W + MSG_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = LEVEL_W + KIND_W + MSG_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [STATE_W-1:0] {
        ALM_INACTIVE = 2'd0,
        ALM_SET      = 2'd1,
        ALM_CLEARED  = 2'd2,
        ALM_UNUSED   = 2'd3
    } alarm_state_t;

endpackage

// File: rtl/alarm_priority_rotator_top.sv
// ----------------------------------------------------------------------------
// alarm_priority_rotator_top
// Picks indicator colour, sound and the rotating alarm message from one scan.
// ----------------------------------------------------------------------------
// Usage:
// The s_ channel carries one alarm table entry per transfer; s_tlast marks
// the final entry of a scan. Entries that are set, or cleared but latched,
// with their channel enabled are active. Over the scan the block tracks the
// highest active level, the highest sound-enabled level with its strongest
// sound kind, and the message to show, which rotates in scan order past the
// one shown after the previous scan among entries at the top level.
// The m_ channel carries one result per scan, registered, in the cycle after
// the transfer that carried s_tlast. One entry is taken every clock cycle
// while s_tready is high; the running compare against the scan registers is
// the whole per-entry path. Reset clears the scan registers, the output
// register and the memory of the last shown message. While a result waits
// on a low m_tready, further entries are held off; s_tready is high whenever
// the output register is empty or being drained in the same cycle.
// ----------------------------------------------------------------------------
module alarm_priority_rotator_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    // Entry: entry_state[1:0], latched[2], channel_on[3], sound_on[4],
    // level[7:5], sound_kind[10:8], message_id[16:11], zero padding above.
    input  logic [apr_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic                          s_tlast,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // Result: colour_level[2:0], sound_out[5:3], shown_message[11:6],
    // zero padding above.
    output logic [apr_pkg::OUT_DATA_W-1:0] m_tdata,
    // Result flag: no_alarm[0].
    output logic                          m_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready
);

    localparam int LW = apr_pkg::LEVEL_W;
    localparam int KW = apr_pkg::KIND_W;
    localparam int MW = apr_pkg::MSG_W;
    localparam int SW = apr_pkg::STATE_W;

    // Unpacked input fields.
    apr_pkg::alarm_state_t in_state;
    logic          in_latched;
    logic          in_channel_on;
    logic          in_sound_on;
    logic [LW-1:0] in_level;
    logic [KW-1:0] in_kind;
    logic [MW-1:0] in_msg;

    assign in_state      = apr_pkg::alarm_state_t'(s_tdata[SW-1:0]);
    assign in_latched    = s_tdata[SW];
    assign in_channel_on = s_tdata[SW+1];
    assign in_sound_on   = s_tdata[SW+2];
    assign in_level      = s_tdata[SW+3 +: LW];
    assign in_kind       = s_tdata[SW+3+LW +: KW];
    assign in_msg        = s_tdata[SW+3+LW+KW +: MW];

    // Scan registers.
    logic [LW-1:0] colour_reg,     colour_next;
    logic [LW-1:0] snd_level_reg,  snd_level_next;
    logic [KW-1:0] snd_kind_reg,   snd_kind_next;
    logic          first_v_reg,    first_v_next;
    logic [MW-1:0] first_id_reg,   first_id_next;
    logic          prev_seen_reg,  prev_seen_next;
    logic          after_v_reg,    after_v_next;
    logic [MW-1:0] after_id_reg,   after_id_next;
    logic          shown_v_reg,    shown_v_next;
    logic [MW-1:0] shown_id_reg,   shown_id_next;

    // Output register.
    logic                         out_valid_reg, out_valid_next;
    logic [apr_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                         out_flag_reg,  out_flag_next;

    logic          accept;
    logic          active;
    logic          level_up;
    logic [LW-1:0] colour_a;
    logic          first_v_a;
    logic          prev_seen_a;
    logic          after_v_a;
    logic [MW-1:0] after_id_a;
    logic          at_top;
    logic          snd_hit;
    logic [LW-1:0] sc_colour;
    logic [KW-1:0] sc_kind;
    logic          sc_first_v;
    logic [MW-1:0] sc_first_id;
    logic          sc_prev_seen;
    logic          sc_after_v;
    logic [MW-1:0] sc_after_id;
    logic [MW-1:0] pick;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        active = in_channel_on && ((in_state == apr_pkg::ALM_SET) ||
                 ((in_state == apr_pkg::ALM_CLEARED) && in_latched));

        // A new highest level restarts the rotation search.
        level_up    = active && (in_level > colour_reg);
        colour_a    = level_up ? in_level : colour_reg;
        first_v_a   = level_up ? 1'b0 : first_v_reg;
        prev_seen_a = level_up ? 1'b0 : prev_seen_reg;
        after_v_a   = level_up ? 1'b0 : after_v_reg;
        after_id_a  = level_up ? '0 : after_id_reg;
        at_top      = active && (in_level == colour_a);

        sc_colour   = colour_a;
        sc_first_v  = first_v_a || at_top;
        sc_first_id = (at_top && !first_v_a) ? in_msg : first_id_reg;
        sc_after_v  = after_v_a || (at_top && first_v_a && prev_seen_a);
        sc_after_id = (at_top && first_v_a && prev_seen_a && !after_v_a) ?
                      in_msg : after_id_a;
        sc_prev_seen = prev_seen_a ||
                       (at_top && shown_v_reg && (in_msg == shown_id_reg));

        snd_hit        = active && in_sound_on;
        snd_level_next = snd_level_reg;
        sc_kind        = snd_kind_reg;
        if (snd_hit && (in_level > snd_level_reg))
        begin
            snd_level_next = in_level;
            sc_kind        = in_kind;
        end
        else if (snd_hit && (in_level == snd_level_reg) && (in_kind > snd_kind_reg))
        begin
            sc_kind = in_kind;
        end

        pick = (sc_prev_seen && sc_after_v) ? sc_after_id : sc_first_id;

        // Defaults: hold everything.
        colour_next    = colour_reg;
        snd_kind_next  = snd_kind_reg;
        first_v_next   = first_v_reg;
        first_id_next  = first_id_reg;
        prev_seen_next = prev_seen_reg;
        after_v_next   = after_v_reg;
        after_id_next  = after_id_reg;
        shown_v_next   = shown_v_reg;
        shown_id_next  = shown_id_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_flag_next  = out_flag_reg;

        if (accept && !s_tlast)
        begin
            colour_next    = sc_colour;
            snd_kind_next  = sc_kind;
            first_v_next   = sc_first_v;
            first_id_next  = sc_first_id;
            prev_seen_next = sc_prev_seen;
            after_v_next   = sc_after_v;
            after_id_next  = sc_after_id;
        end
        else if (accept)
        begin
            // End of scan: publish the result and start a fresh scan.
            out_valid_next = 1'b1;
            out_flag_next  = !sc_first_v;
            out_data_next  = '0;
            out_data_next[LW-1:0]          = sc_colour;
            out_data_next[LW +: KW]        = sc_kind;
            out_data_next[LW+KW +: MW]     = sc_first_v ? pick : '0;
            shown_v_next   = sc_first_v;
            shown_id_next  = sc_first_v ? pick : '0;
            colour_next    = '0;
            snd_level_next = '0;
            snd_kind_next  = '0;
            first_v_next   = 1'b0;
            first_id_next  = '0;
            prev_seen_next = 1'b0;
            after_v_next   = 1'b0;
            after_id_next  = '0;
        end
        else
        begin
            snd_level_next = snd_level_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colour_reg    <= '0;
            snd_level_reg <= '0;
            snd_kind_reg  <= '0;
            first_v_reg   <= 1'b0;
            first_id_reg  <= '0;
            prev_seen_reg <= 1'b0;
            after_v_reg   <= 1'b0;
            after_id_reg  <= '0;
            shown_v_reg   <= 1'b0;
            shown_id_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_flag_reg  <= 1'b0;
        end
        else
        begin
            colour_reg    <= colour_next;
            snd_level_reg <= snd_level_next;
            snd_kind_reg  <= snd_kind_next;
            first_v_reg   <= first_v_next;
            first_id_reg  <= first_id_next;
            prev_seen_reg <= prev_seen_next;
            after_v_reg   <= after_v_next;
            after_id_reg  <= after_id_next;
            shown_v_reg   <= shown_v_next;
            shown_id_reg  <= shown_id_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            out_flag_reg  <= out_flag_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_flag_reg;

endmodule

// File: rtl/apr_checker.sv
// ----------------------------------------------------------------------------
// apr_checker
// Port-level checks for the alarm priority rotator, bound to the top level.
// ----------------------------------------------------------------------------
`include "alarm_priority_rotator_top_assert.svh"

module apr_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tlast,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [apr_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                           m_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready
);

    logic in_xfer_last;

    assign in_xfer_last = s_tvalid && s_tready && s_tlast;

    // A stalled result must hold still.
    `APR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
                     m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // With no active alarm every result field is zero.
    `APR_ASSERT_NOW(a_none_zero, m_tvalid && m_tuser,
                    m_tdata == '0)

    // A result only follows a transfer that closed a scan.
    `APR_ASSERT_NOW(a_result_after_last, $rose(m_tvalid),
                    $past(in_xfer_last))

    // An empty output register never holds off the input.
    `APR_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready)

endmodule

bind alarm_priority_rotator_top apr_checker u_apr_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tlast  (s_tlast),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
